[rtl/wsd_pkg.sv]
// Shared types and constants for the window standard-deviation peak detector.
// No dependencies; the other files of the block import this package, except wsd_checker.
package wsd_pkg;

  // Sample and configuration field widths.
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned COUNT_W  = 10;

  // Saturation value of the sample counter.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

  // Register reset values.
  localparam logic [CFG_W-1:0] MARGIN_RESET = 10'd50;
  localparam logic [CFG_W-1:0] WARMUP_RESET = 10'd10;

  // APB register file geometry.
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Register indexes, taken from address bit 2.
  localparam logic REG_MARGIN = 1'b0;
  localparam logic REG_WARMUP = 1'b1;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QDEPTH = 2;

  // Live configuration seen by the datapath.
  typedef struct packed {
    logic [CFG_W-1:0] peak_margin;
    logic [CFG_W-1:0] warmup_samples;
  } cfg_t;

endpackage

[rtl/wsd_if.sv]
// Valid/ready channel interfaces for samples in and peak results out.
// Depends on wsd_pkg for the sample width.
interface wsd_sample_if;
  import wsd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] filtered_sample;

  modport source (output valid, output filtered_sample, input ready);
  modport sink (input valid, input filtered_sample, output ready);
endinterface

interface wsd_result_if;
  logic valid;
  logic ready;
  logic peak;
  logic warmed_up;

  modport source (output valid, output peak, output warmed_up, input ready);
  modport sink (input valid, input peak, input warmed_up, output ready);
endinterface

[rtl/window_stddev_peak_detector.sv]
// Moving-window mean/standard-deviation peak detector, top level.
// Throughput: one sample per cycle while the queue is not full; the front updates the window sums in one step.
// A result passes through the queue, the test stage and the output register, and a stalled output can hold it.
// Reset (async, active low) clears window, sums, counter and the pipeline at once;
// peak_margin resets to 50 and warmup_samples to 10. No clearing pass is needed.
// Depends on wsd_pkg, wsd_if, wsd_fifo, wsd_front and wsd_back.
module window_stddev_peak_detector #(
  parameter int unsigned WINDOW_LEN = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  wsd_sample_if.sink                   in_sample,
  wsd_result_if.source                 out_result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wsd_pkg::APB_AW-1:0]   paddr,
  input  logic [wsd_pkg::APB_DW-1:0]   pwdata,
  output logic [wsd_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import wsd_pkg::*;

  localparam int unsigned L  = $clog2(WINDOW_LEN);
  localparam int unsigned SW = SAMPLE_W + L;
  localparam int unsigned QW = 2 * SAMPLE_W + L;
  localparam int unsigned JW = 1 + SAMPLE_W + SW + QW;

  logic [CFG_W-1:0] margin_q, warmup_q;
  logic             wr_en;
  cfg_t             cfg;
  logic             push, full, pop, q_valid;
  logic [JW-1:0]    job_in, job_out;

  // Configuration registers.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MARGIN_RESET;
      warmup_q <= WARMUP_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MARGIN: margin_q <= pwdata[CFG_W-1:0];
        REG_WARMUP: warmup_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MARGIN: prdata = APB_DW'(margin_q);
      REG_WARMUP: prdata = APB_DW'(warmup_q);
      default:    prdata = '0;
    endcase
  end

  assign cfg.peak_margin    = margin_q;
  assign cfg.warmup_samples = warmup_q;

  wsd_front #(
    .WINDOW_LEN(WINDOW_LEN), .SW(SW), .QW(QW), .JW(JW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .in_sample(in_sample),
    .full_i   (full),
    .push_o   (push),
    .job_o    (job_in)
  );

  wsd_fifo #(.W(JW)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (job_out)
  );

  wsd_back #(
    .WINDOW_LEN(WINDOW_LEN), .SW(SW), .QW(QW), .JW(JW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (q_valid),
    .job_i     (job_out),
    .pop_o     (pop),
    .out_result(out_result)
  );

endmodule

[rtl/wsd_fifo.sv]
// Short queue that decouples the front part from the back part.
// Depends on wsd_pkg for its depth.
module wsd_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);
  import wsd_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  logic [W-1:0]  mem_q [QDEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[rtl/wsd_front.sv]
// Front part: accepts samples, shifts the window and updates the running sums.
// Depends on wsd_pkg and the wsd_sample_if interface.
module wsd_front #(
  parameter int unsigned WINDOW_LEN = 16,
  parameter int unsigned SW         = 14,
  parameter int unsigned QW         = 24,
  parameter int unsigned JW         = 49
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wsd_pkg::cfg_t       cfg_i,
  wsd_sample_if.sink          in_sample,
  input  logic                full_i,
  output logic                push_o,
  output logic [JW-1:0]       job_o
);
  import wsd_pkg::*;

  logic [SAMPLE_W-1:0]   win_q [WINDOW_LEN];
  logic [SW-1:0]         sum_q, sum_d;
  logic [QW-1:0]         sq_q, sq_d;
  logic [COUNT_W-1:0]    seen_q;
  logic [SAMPLE_W-1:0]   x, oldest;
  logic [2*SAMPLE_W-1:0] x_sq, old_sq;
  logic                  warm;
  logic                  accept;

  // A 10-bit sample never exceeds the clamp limit, so it is used as is.
  assign x      = in_sample.filtered_sample;
  assign oldest = win_q[WINDOW_LEN-1];

  assign in_sample.ready = !full_i;
  assign accept          = in_sample.valid && !full_i;

  // Running sums including the new sample; modular arithmetic stays exact.
  always_comb begin
    x_sq   = (2*SAMPLE_W)'(x) * (2*SAMPLE_W)'(x);
    old_sq = (2*SAMPLE_W)'(oldest) * (2*SAMPLE_W)'(oldest);
    sum_d  = sum_q - SW'(oldest) + SW'(x);
    sq_d   = sq_q - QW'(old_sq) + QW'(x_sq);
    warm   = (seen_q >= cfg_i.warmup_samples);
  end

  assign push_o = accept;
  assign job_o  = {warm, x, sum_d, sq_d};

  // Window shift line, sums and sample counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
      sum_q  <= '0;
      sq_q   <= '0;
      seen_q <= '0;
    end else if (accept) begin
      win_q[0] <= x;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        win_q[i] <= win_q[i-1];
      end
      sum_q <= sum_d;
      sq_q  <= sq_d;
      if (seen_q != COUNT_MAX) begin
        seen_q <= seen_q + 1'b1;
      end
    end
  end

endmodule

[rtl/wsd_back.sv]
// Back part: two-stage peak test and the output register.
// Depends on wsd_pkg and the wsd_result_if interface.
module wsd_back #(
  parameter int unsigned WINDOW_LEN = 16,
  parameter int unsigned SW         = 14,
  parameter int unsigned QW         = 24,
  parameter int unsigned JW         = 49
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wsd_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  input  logic [JW-1:0] job_i,
  output logic          pop_o,
  wsd_result_if.source  out_result
);
  import wsd_pkg::*;

  localparam int unsigned PW = 2 * SW;

  logic                warm;
  logic [SAMPLE_W-1:0] x;
  logic [SW-1:0]       s;
  logic [QW-1:0]       q;
  logic [SW-1:0]       nx, nm;
  logic [SW:0]         d;
  logic [PW-1:0]       var_n2;

  logic                s1_valid_q, s1_warm_q;
  logic [SW:0]         s1_d_q;
  logic [PW-1:0]       s1_var_q;
  logic [SW-1:0]       s1_nm_q;

  logic                out_valid_q, out_peak_q, out_warm_q;
  logic                out_ld, s1_ld;
  logic [SW-1:0]       dmag;
  logic [PW-1:0]       dd;
  logic                peak;

  assign {warm, x, s, q} = job_i;

  // Stall chain: each stage loads when the stage after it can move.
  assign out_ld = !out_valid_q || out_result.ready;
  assign s1_ld  = !s1_valid_q || out_ld;
  assign pop_o  = valid_i && s1_ld;

  // Stage 1: N times the excess over the mean and N^2 times the variance.
  always_comb begin
    nx     = SW'(x) * SW'(WINDOW_LEN);
    nm     = SW'(cfg_i.peak_margin) * SW'(WINDOW_LEN);
    d      = {1'b0, nx} - {1'b0, s};
    var_n2 = PW'(q) * PW'(WINDOW_LEN) - PW'(s) * PW'(s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ld) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ld) begin
      s1_warm_q <= warm;
      s1_d_q    <= d;
      s1_var_q  <= var_n2;
      s1_nm_q   <= nm;
    end
  end

  // Stage 2: square the excess and compare against variance and margin.
  always_comb begin
    dmag = s1_d_q[SW-1:0];
    dd   = PW'(dmag) * PW'(dmag);
    peak = s1_warm_q && !s1_d_q[SW] && (dmag != '0)
           && (dd > s1_var_q) && (dmag > s1_nm_q);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_peak_q <= peak;
      out_warm_q <= s1_warm_q;
    end
  end

  assign out_result.valid     = out_valid_q;
  assign out_result.peak      = out_peak_q;
  assign out_result.warmed_up = out_warm_q;

endmodule

[rtl/wsd_checker.sv]
// Port-level checks for the peak detector, bound to its top level.
// Depends only on the top level's ports.
module wsd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_peak_i,
  input logic out_warm_i
);

  logic [3:0] pending_q;
  logic       in_beat, out_beat;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // Count beats taken in but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_beat && !out_beat) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_beat && !in_beat) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // A stalled result keeps its valid and its bits.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_peak_i) && $stable(out_warm_i))
    else $error("result changed while stalled");

  // A peak is only reported once warm-up is over.
  a_peak_warm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !out_peak_i || out_warm_i)
    else $error("peak reported during warm-up");

  // No result without a sample behind it.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 4'd0)
    else $error("result with no pending sample");

  // Queue, test stage and output register hold at most four samples.
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 4'd4)
    else $error("too many samples in flight");

endmodule

bind window_stddev_peak_detector wsd_checker u_wsd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_sample.valid),
  .in_ready_i (in_sample.ready),
  .out_valid_i(out_result.valid),
  .out_ready_i(out_result.ready),
  .out_peak_i (out_result.peak),
  .out_warm_i (out_result.warmed_up)
);

[test/window_stddev_peak_detector_tb.sv]
// Self-checking testbench for window_stddev_peak_detector: random and directed samples with
// random stalls on both channels, checked against an in-bench peak predictor.
// Depends on wsd_pkg, the wsd_if interfaces and the block's RTL.
module window_stddev_peak_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsd_pkg::*;

  localparam int WIN_LEN = 16;
  localparam int SUM_W   = SAMPLE_W + $clog2(WIN_LEN);
  localparam int SQ_W    = 2 * SAMPLE_W + $clog2(WIN_LEN);
  localparam int RAND_PER_PHASE = 150;
  localparam int STALL_LIMIT    = 2000;
  localparam int SQUEEZE_AT     = 300;
  localparam int SQUEEZE_LEN    = 150;
  localparam int TAIL_CYCLES    = 8;
  localparam int IDLE_CYCLES    = 6;
  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = '1;
  localparam logic [APB_AW-1:0] MARGIN_ADDR = {REG_MARGIN, 2'b00};
  localparam logic [APB_AW-1:0] WARMUP_ADDR = {REG_WARMUP, 2'b00};

  typedef struct packed {
    logic peak;
    logic warmed_up;
  } peak_result_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  wsd_sample_if sample_ch ();
  wsd_result_if result_ch ();

  window_stddev_peak_detector #(
    .WINDOW_LEN(WIN_LEN)
  ) u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_sample (sample_ch.sink),
    .out_result(result_ch.source),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Samples waiting to be offered, and peak results waiting to come out.
  logic [SAMPLE_W-1:0] pending_samples[$];
  peak_result_t        expected_peaks[$];

  // Predictor state and its copy of the configuration.
  logic [SAMPLE_W-1:0] win[WIN_LEN];
  logic [SUM_W-1:0]    win_sum;
  logic [SQ_W-1:0]     win_sq;
  logic [COUNT_W-1:0]  samples_seen;
  logic [CFG_W-1:0]    cfg_margin;
  logic [CFG_W-1:0]    cfg_warmup;

  // Handshake bookkeeping shared by the clocked processes.
  bit          sample_taken;
  bit          result_taken;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned send_gap, send_burst;
  int unsigned recv_gap, recv_burst;
  int unsigned squeeze_left;
  bit          squeeze_done;

  // Clock with a 4 ns period.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Mostly short gaps, some long ones, and now and then a burst with no gaps at all.
  function automatic int unsigned pick_gap(inout int unsigned burst);
    int unsigned r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > int'(SAMPLE_TOP)) return SAMPLE_TOP;
    return v[SAMPLE_W-1:0];
  endfunction

  // Shifts one sample into the window and works out its peak and warm-up flags.
  function automatic peak_result_t predict_peak(input logic [SAMPLE_W-1:0] x);
    peak_result_t        r;
    logic [SAMPLE_W-1:0] oldest;
    logic [SQ_W-1:0]     old_sq;
    logic [SQ_W-1:0]     new_sq;
    longint              xl, s, q, d, var_n2;
    oldest = win[WIN_LEN-1];
    for (int i = WIN_LEN - 1; i >= 1; i--) win[i] = win[i-1];
    win[0] = x;
    old_sq = SQ_W'(oldest) * SQ_W'(oldest);
    new_sq = SQ_W'(x) * SQ_W'(x);
    win_sum = win_sum - SUM_W'(oldest) + SUM_W'(x);
    win_sq = win_sq - old_sq + new_sq;
    r.warmed_up = (samples_seen >= cfg_warmup);
    if (samples_seen < COUNT_MAX) samples_seen++;
    r.peak = 1'b0;
    if (r.warmed_up) begin
      xl = longint'(x);
      s = longint'(win_sum);
      q = longint'(win_sq);
      d = WIN_LEN * xl - s;
      var_n2 = WIN_LEN * q - s * s;
      if (d > 0 && d * d > var_n2 && d > WIN_LEN * longint'(cfg_margin)) r.peak = 1'b1;
    end
    return r;
  endfunction

  // Monitor: predicts on each sample beat and checks each result beat.
  always @(posedge clk) begin : monitor
    peak_result_t want;
    if (rst_n) begin
      sample_taken = sample_ch.valid && sample_ch.ready;
      result_taken = result_ch.valid && result_ch.ready;
      if (sample_taken) expected_peaks.push_back(predict_peak(sample_ch.filtered_sample));
      if (result_taken) begin
        results_seen++;
        if (expected_peaks.size() == 0) begin
          report_error("result beat with no sample outstanding");
        end else begin
          want = expected_peaks.pop_front();
          if (result_ch.peak !== want.peak)
            report_error($sformatf("result %0d: peak %b, expected %b",
                                   results_seen, result_ch.peak, want.peak));
          if (result_ch.warmed_up !== want.warmed_up)
            report_error($sformatf("result %0d: warmed_up %b, expected %b",
                                   results_seen, result_ch.warmed_up, want.warmed_up));
        end
      end
      // Watchdog on cycles with no beat on either channel.
      if (sample_taken || result_taken) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("ERROR: no beat for %0d cycles", STALL_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // Sample driver: holds each beat until it is taken, with random gaps between beats.
  always @(negedge clk) begin
    if (!rst_n) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_taken) void'(pending_samples.pop_front());
      if (sample_ch.valid && !sample_taken) begin
        sample_ch.valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        sample_ch.valid <= 1'b0;
        sample_ch.filtered_sample <= SAMPLE_W'($urandom);
      end else if (pending_samples.size() > 0) begin
        sample_ch.valid <= 1'b1;
        sample_ch.filtered_sample <= pending_samples[0];
        send_gap = pick_gap(send_burst);
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off that backs up the block.
  always @(negedge clk) begin
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
      squeeze_done = 1'b1;
      squeeze_left = SQUEEZE_LEN - 1;
      result_ch.ready <= 1'b0;
    end else if (squeeze_left > 0) begin
      squeeze_left--;
      result_ch.ready <= 1'b0;
    end else begin
      if (recv_gap == 0 && (result_taken || $urandom_range(0, 15) == 0))
        recv_gap = pick_gap(recv_burst);
      if (recv_gap > 0) begin
        recv_gap--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] value);
    logic [APB_DW-1:0] data;
    data = $urandom;
    data[CFG_W-1:0] = value;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [APB_AW-1:0] addr, input logic [CFG_W-1:0] want);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== APB_DW'(want))
      report_error($sformatf("register at %0d reads %0h, expected %0h", addr, prdata, want));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every result is in and the pipeline has drained.
  task automatic wait_idle();
    while (pending_samples.size() != 0 || expected_peaks.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] margin, input logic [CFG_W-1:0] warmup);
    wait_idle();
    apb_write(MARGIN_ADDR, margin);
    apb_write(WARMUP_ADDR, warmup);
    cfg_margin = margin;
    cfg_warmup = warmup;
    apb_read_check(MARGIN_ADDR, margin);
    apb_read_check(WARMUP_ADDR, warmup);
  endtask

  // Mostly a quiet baseline followed by a spike, with some noise and extreme runs.
  task automatic queue_random(input int count);
    int n, r, base, amp, len;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        base = $urandom_range(0, 1023);
        amp = $urandom_range(0, 40);
        len = $urandom_range(6, 20);
        repeat (len) pending_samples.push_back(clamp_sample(base + $urandom_range(0, 2 * amp) - amp));
        pending_samples.push_back(clamp_sample(base + $urandom_range(0, 1023)));
        n += len + 1;
      end else if (r < 88) begin
        pending_samples.push_back(SAMPLE_W'($urandom));
        n++;
      end else begin
        len = $urandom_range(1, 5);
        repeat (len) pending_samples.push_back($urandom_range(0, 1) ? SAMPLE_TOP : '0);
        n += len;
      end
    end
  endtask

  // Reset, directed samples at the reset configuration, then random phases.
  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.filtered_sample = '0;
    result_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    for (int i = 0; i < WIN_LEN; i++) win[i] = '0;
    win_sum = '0;
    win_sq = '0;
    samples_seen = '0;
    cfg_margin = MARGIN_RESET;
    cfg_warmup = WARMUP_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extremes and a walking one that runs past the end of warm-up, then spikes.
    pending_samples.push_back('0);
    pending_samples.push_back(SAMPLE_TOP);
    pending_samples.push_back('0);
    pending_samples.push_back(SAMPLE_TOP);
    for (int b = 0; b < SAMPLE_W; b++) pending_samples.push_back(SAMPLE_W'(1) << b);
    pending_samples.push_back(SAMPLE_TOP);
    pending_samples.push_back(SAMPLE_TOP);
    pending_samples.push_back(10'd341);
    pending_samples.push_back(10'd682);
    repeat (3) pending_samples.push_back(10'd5);
    pending_samples.push_back(10'd200);
    pending_samples.push_back(SAMPLE_TOP);

    // No margin and no warm-up.
    set_config('0, '0);
    queue_random(RAND_PER_PHASE);
    // Largest margin and warm-up: nothing can pass.
    set_config(SAMPLE_TOP, SAMPLE_TOP);
    queue_random(RAND_PER_PHASE);
    // Warm-up ends a few samples into the phase.
    wait_idle();
    set_config(10'd20, (samples_seen > COUNT_MAX - 5) ? COUNT_MAX : samples_seen + 10'd5);
    queue_random(RAND_PER_PHASE);
    set_config(10'd300, 10'd10);
    queue_random(RAND_PER_PHASE);
    set_config(CFG_W'($urandom_range(0, 120)), CFG_W'($urandom));
    queue_random(RAND_PER_PHASE);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
